// ===== rtl/lph_pkg.sv =====
// Package: types, constants and helpers for the linear probe hash table.
package lph_pkg;

    localparam int MaxSlots  = 1024;
    localparam int SlotW     = $clog2(MaxSlots);
    localparam int SizeW     = SlotW + 1;
    localparam int KeyBytes  = 8;
    localparam int KeyW      = 64;
    localparam int ValW      = 64;
    localparam int HashW     = 64;
    localparam int QDepth    = 2;
    localparam logic [7:0] CaseBit = 8'd32;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_SEARCH = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_FIRST  = 3'd3,
        ACT_NEXT   = 3'd4
    } action_t;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOMORE   = 3'd4;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_VALID   = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [2:0]      action;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [SlotW-1:0] slot;
        logic [KeyW-1:0]  found_key;
        logic [ValW-1:0]  found_value;
        logic [SizeW-1:0] count;
    } rsp_t;

    // front to back: normalised request with its hash
    typedef struct packed {
        logic [2:0]       action;
        logic [KeyW-1:0]  key;
        logic [ValW-1:0]  value;
        logic [HashW-1:0] hash;
    } job_t;

    function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] k);
        logic [KeyW-1:0] r;
        logic            live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < KeyBytes; i++) begin
            if (k[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + CaseBit : b;
    endfunction

endpackage

// ===== rtl/lph_ram.sv =====
// Generic single-port RAM with registered read.
module lph_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/lph_front.sv =====
// Front end: accepts requests, normalises the key and hashes it byte by byte.
module lph_front (
    input  logic          clk,
    input  logic          rst_n,
    input  lph_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output lph_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_full
);
    import lph_pkg::*;

    localparam int BW = $clog2(KeyBytes + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BW-1:0]    idx_reg, idx_next;
    job_t             job_reg, job_next;
    logic [7:0]       b;

    assign req_stall = busy_reg;
    assign job_valid = done_reg;
    assign job       = job_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        idx_next  = idx_reg;
        job_next  = job_reg;
        b         = job_reg.key[8*idx_reg[BW-1:0] +: 8];
        if (done_reg && !job_full)
        begin
            done_next = 1'b0;
            busy_next = 1'b0;
        end
        if (!busy_reg && req_valid)
        begin
            busy_next       = 1'b1;
            idx_next        = '0;
            job_next.action = req.action;
            job_next.key    = norm_key(req.key);
            job_next.value  = req.value;
            job_next.hash   = '0;
        end
        else if (busy_reg && !done_reg)
        begin
            // one key byte a cycle; stop at the terminator
            if (idx_reg == BW'(KeyBytes) || b == 8'd0)
                done_next = 1'b1;
            else
            begin
                job_next.hash = (job_reg.hash << 5) + job_reg.hash
                                + HashW'(lower(b));
                idx_next      = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        job_reg <= job_next;
    end
endmodule

// ===== rtl/lph_queue.sv =====
// Short FIFO between front and back end.
module lph_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  lph_pkg::job_t wr_data,
    input  logic          wr_en,
    output logic          full,
    output lph_pkg::job_t rd_data,
    output logic          rd_valid,
    input  logic          rd_en
);
    import lph_pkg::*;

    localparam int PW = $clog2(QDepth);

    job_t          q_reg [QDepth];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   n_reg;

    assign full     = (n_reg == (PW+1)'(QDepth));
    assign rd_valid = (n_reg != '0);
    assign rd_data  = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full) wp_reg <= wp_reg + 1'b1;
            if (rd_en && rd_valid) rp_reg <= rp_reg + 1'b1;
            n_reg <= n_reg + (PW+1)'(wr_en && !full) - (PW+1)'(rd_en && rd_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full) q_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== rtl/lph_back.sv =====
// Back end: modulo reduction, probe walk, slot update and first/next slot scan.
module lph_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [lph_pkg::SizeW-1:0] table_size,
    input  lph_pkg::job_t           job,
    input  logic                    job_valid,
    output logic                    job_take,
    output lph_pkg::rsp_t           rsp,
    output logic                    rsp_valid,
    input  logic                    rsp_stall
);
    import lph_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_READ  = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_WRITE = 9'b000100000,
        S_FETCH = 9'b001000000,
        S_GET   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t           st_reg, st_next;
    job_t             job_reg, job_next;
    logic [HashW-1:0] rem_reg, rem_next;
    logic [6:0]       bit_reg, bit_next;
    logic [SizeW-1:0] size_reg, size_next;
    logic [SlotW-1:0] idx_reg, idx_next;
    logic [SizeW-1:0] n_reg, n_next;
    logic             hf_reg, hf_next;
    logic [SlotW-1:0] free_reg, free_next;
    logic [SizeW-1:0] cnt_reg, cnt_next;
    logic [SizeW-1:0] cur_reg, cur_next;
    rsp_t             rsp_reg, rsp_next;

    logic             m_we, k_we;
    logic [SlotW-1:0] addr;
    logic [1:0]       m_wd, m_rd;
    logic [KeyW-1:0]  k_rd;
    logic [ValW-1:0]  v_rd;
    logic [HashW:0]   trial;
    logic [SlotW-1:0] idx_inc;

    lph_ram #(.Width(2), .Depth(MaxSlots)) u_mark (
        .clk(clk), .we(m_we), .addr(addr), .wdata(m_wd), .rdata(m_rd));
    lph_ram #(.Width(KeyW), .Depth(MaxSlots)) u_key (
        .clk(clk), .we(k_we), .addr(addr), .wdata(job_reg.key), .rdata(k_rd));
    lph_ram #(.Width(ValW), .Depth(MaxSlots)) u_val (
        .clk(clk), .we(k_we), .addr(addr), .wdata(job_reg.value), .rdata(v_rd));

    assign rsp       = rsp_reg;
    assign rsp_valid = (st_reg == S_OUT);
    assign job_take  = (st_reg == S_IDLE) && job_valid;
    assign idx_inc   = (SizeW'(idx_reg) + 1'b1 == size_reg) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        st_next    = st_reg;
        job_next   = job_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        hf_next    = hf_reg;
        free_next  = free_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        rsp_next   = rsp_reg;
        m_we       = 1'b0;
        k_we       = 1'b0;
        m_wd       = MARK_VALID;
        addr       = idx_reg;
        trial      = {rem_reg, job_reg.hash[bit_reg[5:0]]} - {{(HashW-SizeW+1){1'b0}}, size_reg};
        case (st_reg)
            S_CLEAR:
            begin
                // sweep all slots to empty after reset
                m_we     = 1'b1;
                m_wd     = MARK_EMPTY;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SlotW'(MaxSlots - 1)) st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_next  = job;
                    size_next = (table_size == '0) ? SizeW'(1) :
                                (table_size > SizeW'(MaxSlots)) ? SizeW'(MaxSlots) :
                                table_size;
                    rem_next  = '0;
                    bit_next  = 7'(HashW);
                    n_next    = '0;
                    hf_next   = 1'b0;
                    rsp_next  = '{status: ST_NOTFOUND, slot: '0, found_key: '0,
                                  found_value: '0, count: cnt_reg};
                    case (job.action)
                        ACT_INSERT, ACT_SEARCH, ACT_ERASE: st_next = S_MOD;
                        ACT_FIRST:
                        begin
                            cur_next = cur_reg;
                            idx_next = '0;
                            n_next   = '0;
                            st_next  = S_FETCH;
                        end
                        ACT_NEXT:
                        begin
                            n_next  = cur_reg;
                            st_next = S_FETCH;
                        end
                        default: st_next = S_OUT;
                    endcase
                end
            end
            S_MOD:
            begin
                // restoring remainder, one hash bit a cycle
                if (bit_reg == '0)
                begin
                    idx_next = rem_reg[SlotW-1:0];
                    st_next  = S_READ;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                    trial    = {rem_reg, job_reg.hash[6'(bit_reg - 1'b1)]}
                               - {{(HashW-SizeW+1){1'b0}}, size_reg};
                    if (!trial[HashW])
                        rem_next = trial[HashW-1:0];
                    else
                        rem_next = {rem_reg[HashW-2:0], job_reg.hash[6'(bit_reg - 1'b1)]};
                end
            end
            S_READ:
            begin
                if (n_reg == size_reg)
                    st_next = S_WRITE;
                else
                    st_next = S_EVAL;
            end
            S_EVAL:
            begin
                st_next = S_READ;
                n_next  = n_reg + 1'b1;
                idx_next = idx_inc;
                if (m_rd == MARK_VALID)
                begin
                    if (k_rd == job_reg.key)
                    begin
                        rsp_next.slot        = idx_reg;
                        rsp_next.found_key   = k_rd;
                        rsp_next.found_value = v_rd;
                        idx_next = idx_reg;
                        case (job_reg.action)
                            ACT_INSERT:
                            begin
                                rsp_next.status = ST_DUP;
                                st_next = S_OUT;
                            end
                            ACT_ERASE:
                            begin
                                rsp_next.status = ST_DONE;
                                m_we     = 1'b1;
                                m_wd     = MARK_DELETED;
                                cnt_next = cnt_reg - 1'b1;
                                rsp_next.count = cnt_reg - 1'b1;
                                cur_next = SizeW'(idx_reg) + 1'b1;
                                st_next  = S_OUT;
                            end
                            default:
                            begin
                                rsp_next.status = ST_DONE;
                                cur_next = SizeW'(idx_reg) + 1'b1;
                                st_next  = S_OUT;
                            end
                        endcase
                    end
                end
                else
                begin
                    if (!hf_reg)
                    begin
                        hf_next   = 1'b1;
                        free_next = idx_reg;
                    end
                    if (m_rd == MARK_EMPTY)
                    begin
                        if (job_reg.action == ACT_INSERT)
                            st_next = S_WRITE;
                        else
                            st_next = S_OUT;
                    end
                end
            end
            S_WRITE:
            begin
                // reached only by insert at chain end, or after size probes
                if (job_reg.action != ACT_INSERT)
                    st_next = S_OUT;
                else if (!hf_reg)
                begin
                    rsp_next.status = ST_FULL;
                    st_next = S_OUT;
                end
                else
                begin
                    addr = free_reg;
                    m_we = 1'b1;
                    k_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    cur_next = SizeW'(free_reg) + 1'b1;
                    rsp_next = '{status: ST_DONE, slot: free_reg,
                                 found_key: job_reg.key, found_value: job_reg.value,
                                 count: cnt_reg + 1'b1};
                    st_next = S_OUT;
                end
            end
            S_FETCH:
            begin
                // scan marks in slot order; n_reg is the slot under test
                if (n_reg >= size_reg)
                begin
                    rsp_next.status = ST_NOMORE;
                    st_next = S_OUT;
                end
                else
                begin
                    addr    = n_reg[SlotW-1:0];
                    idx_next = n_reg[SlotW-1:0];
                    st_next = S_GET;
                end
            end
            S_GET:
            begin
                if (m_rd == MARK_VALID)
                begin
                    rsp_next.status      = ST_DONE;
                    rsp_next.slot        = idx_reg;
                    rsp_next.found_key   = k_rd;
                    rsp_next.found_value = v_rd;
                    cur_next = SizeW'(idx_reg) + 1'b1;
                    st_next  = S_OUT;
                end
                else
                begin
                    n_next  = n_reg + 1'b1;
                    st_next = S_FETCH;
                end
            end
            S_OUT:
            begin
                if (!rsp_stall) st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLEAR;
            idx_reg <= '0;
            cnt_reg <= '0;
            cur_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        size_reg  <= size_next;
        n_reg     <= n_next;
        hf_reg    <= hf_next;
        free_reg  <= free_next;
        rsp_reg   <= rsp_next;
    end
endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level: linear probing hash table with front hasher, queue and probe engine.
//
//  channel  direction  handshake        payload
//  req      in         req_valid/stall  lph_pkg::req_t
//  rsp      out        rsp_valid/stall  lph_pkg::rsp_t
//  cfg      in         cfg_we           table_size, 11 bits
//
// Hashing takes one key byte a cycle, then a terminator check and the transfer to the queue;
// the back end takes the job from the queue and reduces the hash to the home slot one hash
// bit a cycle. The probe visits each slot in S_READ then S_EVAL on the mark/key/value RAM
// port, insert adds a write in S_WRITE, and the result holds while rsp_stall is high.
// First/next scan marks slot by slot through S_FETCH and S_GET.
// After reset the mark RAM is swept to empty; requests wait.
// The queue lets the front hash the next key while the back end probes.
module linear_probe_hash_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lph_pkg::SizeW-1:0]   cfg_data,
    input  lph_pkg::req_t               req,
    input  logic                        req_valid,
    output logic                        req_stall,
    output lph_pkg::rsp_t               rsp,
    output logic                        rsp_valid,
    input  logic                        rsp_stall
);
    import lph_pkg::*;

    logic [SizeW-1:0] size_reg;
    job_t             f_job, q_job;
    logic             f_valid, q_full, q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= SizeW'(MaxSlots);
        else if (cfg_we) size_reg <= cfg_data;
    end

    lph_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .job(f_job), .job_valid(f_valid), .job_full(q_full));

    lph_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_job), .wr_en(f_valid), .full(q_full),
        .rd_data(q_job), .rd_valid(q_valid), .rd_en(q_take));

    lph_back u_back (
        .clk(clk), .rst_n(rst_n), .table_size(size_reg), .job(q_job),
        .job_valid(q_valid), .job_take(q_take), .rsp(rsp), .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall));

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= SizeW'(MaxSlots))
        else $error("entry count out of range");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_NOTFOUND || rsp.status == ST_FULL ||
         rsp.status == ST_NOMORE)) |-> (rsp.slot == '0 && rsp.found_key == '0))
        else $error("miss carries slot data");
    a_take_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> !rsp_valid)
        else $error("job taken while result pending");
endmodule
